>>> rtl/aging_route_table_assert.svh
// assertion macros used by the route table checker
`ifndef AGING_ROUTE_TABLE_ASSERT_SVH
`define AGING_ROUTE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/art_pkg.sv
// shared types and constants of the aging route table
package art_pkg;

    localparam int CALL_W     = 56;
    localparam int SIG_W      = 9;
    localparam int TIME_W     = 32;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGNAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 8'd1;

    // register reset values
    localparam logic signed [SIG_W-1:0] MIN_SIGNAL_RESET = -9'sd115;
    localparam logic [TIME_W-1:0]       TIMEOUT_RESET    = 32'd120000;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_AGE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_VWRITE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic scan_start;
        logic scan_step;
        logic victim_write;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic out_free;
        logic scan_last;
    } status_t;

endpackage

>>> rtl/art_ctrl.sv
// control state machine of the aging route table
module art_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  art_pkg::status_t status,
    output art_pkg::cmd_t   cmd
);
    import art_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (status.out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_VWRITE;
                end
            end
            ST_VWRITE:
            begin
                if (status.out_free)
                begin
                    cmd.victim_write = 1'b1;
                    cmd.load_out     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/art_dp.sv
// route store, compare lanes, oldest-entry scan and result register
module art_dp
#(
    parameter int ENTRIES = 20
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [art_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [1:0]                         s_tuser,
    input  logic                               cfg_valid,
    input  logic [art_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [art_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    input  art_pkg::cmd_t                      cmd,
    output art_pkg::status_t                   status
);
    import art_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    // configuration registers
    logic signed [SIG_W-1:0] min_sig_reg;
    logic [TIME_W-1:0]       timeout_reg;

    // route store
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [CALL_W-1:0]  dest_mem  [ENTRIES];
    logic [CALL_W-1:0]  hop_mem   [ENTRIES];
    logic [TIME_W-1:0]  stamp_mem [ENTRIES];

    // captured request
    mode_t              mode_reg;
    logic [CALL_W-1:0]  dest_reg;
    logic [CALL_W-1:0]  hop_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               weak_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] age_reg;

    // request fields
    logic [CALL_W-1:0]       in_dest;
    logic [CALL_W-1:0]       in_hop;
    logic signed [SIG_W-1:0] in_sig;
    logic [TIME_W-1:0]       in_time;
    logic [ENTRIES-1:0]      match_next;
    logic [ENTRIES-1:0]      age_next;

    // selection
    logic [IW-1:0] fm_idx;
    logic [IW-1:0] ff_idx;
    logic          any_match;
    logic          any_free;
    logic          wr_en;
    logic [IW-1:0] wr_idx;

    // oldest-entry scan
    logic [IW-1:0]     scan_idx_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [TIME_W-1:0] best_stamp_reg;

    // result register
    logic              m_tvalid_reg;
    logic              hit_reg;
    logic [CALL_W-1:0] hop_out_reg;

    assign in_dest = s_tdata[55:0];
    assign in_hop  = s_tdata[111:56];
    assign in_sig  = s_tdata[120:112];
    assign in_time = s_tdata[152:121];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sig_reg <= MIN_SIGNAL_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MIN_SIGNAL)
            begin
                min_sig_reg <= cfg_data[SIG_W-1:0];
            end
            else if (cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data[TIME_W-1:0];
            end
        end
    end

    // per-entry destination match and age test
    always_comb
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            match_next[k] = valid_reg[k] && (dest_mem[k] == in_dest);
            age_next[k]   = valid_reg[k] &&
                            (TIME_W'(in_time - stamp_mem[k]) > timeout_reg);
        end
    end

    // capture the request with its compare results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode_t'(s_tuser);
            dest_reg  <= in_dest;
            hop_reg   <= in_hop;
            time_reg  <= in_time;
            weak_reg  <= (in_sig < min_sig_reg);
            match_reg <= match_next;
            age_reg   <= age_next;
        end
    end

    // first match and first free entry
    always_comb
    begin
        fm_idx = '0;
        ff_idx = '0;
        for (int k = ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                fm_idx = IW'(k);
            end
            if (!valid_reg[k])
            begin
                ff_idx = IW'(k);
            end
        end
    end

    assign any_match = |match_reg;
    assign any_free  = ~&valid_reg;

    // write slot selection
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = fm_idx;
        if (cmd.commit && (mode_reg == MODE_UPDATE) && !weak_reg)
        begin
            if (any_match)
            begin
                wr_en = 1'b1;
            end
            else if (any_free)
            begin
                wr_en  = 1'b1;
                wr_idx = ff_idx;
            end
        end
        if (cmd.victim_write)
        begin
            wr_en  = 1'b1;
            wr_idx = best_idx_reg;
        end
    end

    // valid bits: delete, aging and fills
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit && (mode_reg == MODE_DELETE))
        begin
            valid_next = valid_reg & ~match_reg;
        end
        else if (cmd.commit && (mode_reg == MODE_AGE))
        begin
            valid_next = valid_reg & ~age_reg;
        end
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_mem[wr_idx]  <= dest_reg;
            hop_mem[wr_idx]   <= hop_reg;
            stamp_mem[wr_idx] <= time_reg;
        end
    end

    // oldest stamp scan, one entry a cycle, lowest index wins a tie
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_idx_reg   <= IW'(1);
            best_idx_reg   <= '0;
            best_stamp_reg <= stamp_mem[0];
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
            if (stamp_mem[scan_idx_reg] < best_stamp_reg)
            begin
                best_idx_reg   <= scan_idx_reg;
                best_stamp_reg <= stamp_mem[scan_idx_reg];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            hit_reg     <= ((mode_reg == MODE_LOOKUP) || (mode_reg == MODE_DELETE)) &&
                           any_match;
            hop_out_reg <= ((mode_reg == MODE_LOOKUP) && any_match) ? hop_mem[fm_idx] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = hop_out_reg;
    assign m_tuser  = hit_reg;

    // status to the controller
    assign status.need_scan = (mode_reg == MODE_UPDATE) && !weak_reg && !any_match &&
                              !any_free;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.scan_last = (scan_idx_reg == IW'(ENTRIES - 1));

endmodule

>>> rtl/aging_route_table.sv
// top level of the aging route table
// Route table of ENTRIES callsign routes with aging and oldest-entry
// replacement. One request goes in at a time and gives one result. The
// accept cycle compares the destination and the age of every entry in
// parallel lanes; ST_EXEC then writes the store and loads the result
// register. An update that finds no match and no free entry instead
// scans the stored stamps one entry a cycle for the oldest and replaces
// it. The result register holds a result until it is taken; a request
// may be accepted meanwhile, and its write and result load wait for the
// register to free. Valid bits clear at reset, so the table is usable at
// once. Configuration (cfg_index 0 is the signal floor, 1 is the route
// timeout, other indexes are ignored) is always ready and must be
// written only while the block is idle.
module aging_route_table
#(
    parameter int ENTRIES = 20
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dest_call[55:0], hop_call[111:56], signal_dbm[120:112],
    // time_now_ms[152:121], zero fill [159:153]
    input  logic [art_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hop_out[55:0]
    output logic [art_pkg::OUT_DATA_W-1:0] m_tdata,
    // hit[0]
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0] cfg_data
);
    import art_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // control state machine
    art_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and datapath
    art_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> rtl/art_checker.sv
// port checker of the aging route table and its bind
`include "aging_route_table_assert.svh"

module art_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata,
    input logic         m_tuser
);

    // a stalled result stays put
    `ART_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // a result without hit carries no next hop
    `ART_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 56'd0, "next hop set without hit")

    // one request at a time: busy right after an accept
    `ART_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "request accepted back to back")

endmodule

bind aging_route_table art_checker u_art_checker (.*);

>>> test/testbench.sv
// self-checking testbench of the aging route table
`timescale 1ns / 1ps

module testbench;

    import art_pkg::*;

    localparam int ENTRIES     = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int CALL_POOL   = 28;

    // index that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    localparam logic [CALL_W-1:0] CALL_ONES = {CALL_W{1'b1}};
    localparam logic [CALL_W-1:0] CALL_ZERO = '0;

    typedef struct {
        mode_t                    mode;
        logic [CALL_W-1:0]        dest;
        logic [CALL_W-1:0]        hop;
        logic signed [SIG_W-1:0]  sig_dbm;
        logic [TIME_W-1:0]        now_ms;
    } route_op_t;

    typedef struct {
        logic              hit;
        logic [CALL_W-1:0] hop;
    } route_answer_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = MODE_UPDATE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // operations waiting to be sent, and answers waiting to come back
    route_op_t     route_ops[$];
    route_answer_t route_answers[$];
    route_op_t     cur_op;

    // shadow of the route store and its registers
    logic                    tbl_valid [ENTRIES];
    logic [CALL_W-1:0]       tbl_dest  [ENTRIES];
    logic [CALL_W-1:0]       tbl_hop   [ENTRIES];
    logic [TIME_W-1:0]       tbl_stamp [ENTRIES];
    logic signed [SIG_W-1:0] min_sig_dbm = MIN_SIGNAL_RESET;
    logic [TIME_W-1:0]       age_limit   = TIMEOUT_RESET;

    int err_cnt   = 0;
    int cyc       = 0;
    int stall_cnt = 0;

    aging_route_table #(.ENTRIES(ENTRIES)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // route store after reset
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_dest[i]  = '0;
            tbl_hop[i]   = '0;
            tbl_stamp[i] = '0;
        end
    end

    // apply one operation to the shadow store and give its answer
    function automatic route_answer_t apply_route_op(route_op_t op);
        route_answer_t ans;
        int            victim;
        logic [TIME_W-1:0] age_ms;
        bit            done;
        ans.hit = 1'b0;
        ans.hop = '0;
        done    = 0;
        case (op.mode)
            MODE_UPDATE:
            begin
                if (op.sig_dbm >= min_sig_dbm)
                begin
                    // refresh the first matching route
                    for (int i = 0; i < ENTRIES && !done; i++)
                        if (tbl_valid[i] && tbl_dest[i] == op.dest)
                        begin
                            tbl_hop[i]   = op.hop;
                            tbl_stamp[i] = op.now_ms;
                            done = 1;
                        end
                    // else take a free slot, else the oldest one
                    victim = -1;
                    for (int i = 0; i < ENTRIES && !done && victim < 0; i++)
                        if (!tbl_valid[i])
                            victim = i;
                    if (!done && victim < 0)
                    begin
                        victim = 0;
                        for (int i = 1; i < ENTRIES; i++)
                            if (tbl_stamp[i] < tbl_stamp[victim])
                                victim = i;
                    end
                    if (!done)
                    begin
                        tbl_valid[victim] = 1'b1;
                        tbl_dest[victim]  = op.dest;
                        tbl_hop[victim]   = op.hop;
                        tbl_stamp[victim] = op.now_ms;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES && !done; i++)
                    if (tbl_valid[i] && tbl_dest[i] == op.dest)
                    begin
                        ans.hit = 1'b1;
                        ans.hop = tbl_hop[i];
                        done = 1;
                    end
            end
            MODE_DELETE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_dest[i] == op.dest)
                    begin
                        tbl_valid[i] = 1'b0;
                        ans.hit = 1'b1;
                    end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    age_ms = op.now_ms - tbl_stamp[i];
                    if (tbl_valid[i] && age_ms > age_limit)
                        tbl_valid[i] = 1'b0;
                end
            end
        endcase
        return ans;
    endfunction

    // no breaks in the last part of each cyc period, random gaps otherwise
    function automatic bit take_break();
        if ((cyc % 3000) >= 2400)
            return 0;
        return $urandom_range(99) < 18;
    endfunction

    function automatic logic [CALL_W-1:0] rand_call();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[CALL_W-1:0];
    endfunction

    // space-padded callsign from a small pool, first byte high
    function automatic logic [CALL_W-1:0] callsign(int n);
        logic [7:0] letter;
        logic [7:0] digit;
        letter = 8'h41 + 8'(n % 26);
        digit  = 8'h30 + 8'((n / 26) % 10);
        return {8'h4B, letter, digit, 8'h20, 8'h20, 8'h20, 8'h20};
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_op(input mode_t mode, input logic [CALL_W-1:0] dest,
                          input logic [CALL_W-1:0] hop, input int sig,
                          input logic [TIME_W-1:0] now_ms);
        route_op_t op;
        op.mode    = mode;
        op.dest    = dest;
        op.hop     = hop;
        op.sig_dbm = SIG_W'(sig);
        op.now_ms  = now_ms;
        route_ops.push_back(op);
    endtask

    // mostly well-formed traffic over a small callsign pool, some noise
    task automatic queue_traffic(input int count, input logic [TIME_W-1:0] start_ms,
                                 input logic signed [SIG_W-1:0] floor_dbm);
        logic [TIME_W-1:0] clock_ms;
        route_op_t         op;
        int                roll;
        int                sig;
        clock_ms = start_ms;
        repeat (count)
        begin
            roll = $urandom_range(99);
            sig  = int'($urandom_range(255)) - 157;
            if (roll < 8)
            begin
                op.mode    = mode_t'($urandom_range(3));
                op.dest    = rand_call();
                op.hop     = rand_call();
                op.sig_dbm = SIG_W'(sig);
                op.now_ms  = $urandom;
            end
            else
            begin
                if ($urandom_range(3) != 0)
                    clock_ms += $urandom_range(30000);
                roll = $urandom_range(99);
                if (roll < 45)
                    op.mode = MODE_UPDATE;
                else if (roll < 75)
                    op.mode = MODE_LOOKUP;
                else if (roll < 90)
                    op.mode = MODE_DELETE;
                else
                    op.mode = MODE_AGE;
                op.dest    = callsign($urandom_range(CALL_POOL - 1));
                op.hop     = $urandom_range(1) ? callsign($urandom_range(CALL_POOL - 1))
                                               : rand_call();
                op.sig_dbm = ($urandom_range(3) == 0) ? floor_dbm : SIG_W'(sig);
                op.now_ms  = clock_ms;
            end
            route_ops.push_back(op);
        end
    endtask

    // register write; the shadow copy follows at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MIN_SIGNAL)
            min_sig_dbm = val[SIG_W-1:0];
        else if (idx == REG_TIMEOUT)
            age_limit = val;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (route_ops.size() != 0 || s_tvalid || route_answers.size() != 0);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_UPDATE;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                route_answers.push_back(apply_route_op(cur_op));
            if (route_ops.size() != 0 && !take_break())
            begin
                cur_op = route_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, cur_op.now_ms, cur_op.sig_dbm, cur_op.hop, cur_op.dest};
                s_tuser  <= cur_op.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        route_answer_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (route_answers.size() == 0)
                    report_mismatch($sformatf("result with no request waiting: hit %0b hop %h",
                                              m_tuser, m_tdata));
                else
                begin
                    want = route_answers.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch($sformatf("hit %0b, expected %0b", m_tuser, want.hit));
                    if (m_tdata !== want.hop)
                        report_mismatch($sformatf("hop_out %h, expected %h", m_tdata, want.hop));
                end
            end
            m_tready <= !take_break();
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_MIN_SIGNAL, 32'($signed(MIN_SIGNAL_RESET)));
        write_reg(REG_TIMEOUT, TIMEOUT_RESET);

        // directed checks with the reset settings
        @(negedge clk);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        add_op(MODE_UPDATE, CALL_ONES, CALL_ZERO, 98, 32'd0);
        // weak signal is dropped
        add_op(MODE_UPDATE, CALL_ZERO, CALL_ONES, -157, 32'hFFFF_FFFF);
        add_op(MODE_LOOKUP, CALL_ZERO, CALL_ZERO, 0, 32'd0);
        // signal exactly at the floor is taken
        add_op(MODE_UPDATE, CALL_ZERO, CALL_ONES, -115, 32'hFFFF_FFFF);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ONES, 0, 32'd0);
        add_op(MODE_LOOKUP, CALL_ZERO, CALL_ZERO, 0, 32'd0);
        // one below the floor, then a refresh
        add_op(MODE_UPDATE, CALL_ONES, callsign(3), -116, 32'd5);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        add_op(MODE_UPDATE, CALL_ONES, callsign(3), 0, 32'd5);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        // delete hit, then delete miss
        add_op(MODE_DELETE, CALL_ZERO, CALL_ONES, 0, 32'd0);
        add_op(MODE_DELETE, CALL_ZERO, CALL_ONES, 0, 32'd0);
        // age equal to the timeout keeps the route
        add_op(MODE_AGE, CALL_ZERO, CALL_ZERO, 0, 32'd120005);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        // stamp just before the time wraps
        add_op(MODE_UPDATE, callsign(1), callsign(2), -20, 32'hFFFF_FFF0);
        add_op(MODE_AGE, CALL_ONES, CALL_ONES, 0, 32'd100);
        add_op(MODE_LOOKUP, callsign(1), CALL_ZERO, 0, 32'd0);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        // one past the timeout drops both
        add_op(MODE_AGE, CALL_ZERO, CALL_ZERO, 0, 32'd120006);
        add_op(MODE_LOOKUP, CALL_ONES, CALL_ZERO, 0, 32'd0);
        add_op(MODE_LOOKUP, callsign(1), CALL_ZERO, 0, 32'd0);
        add_op(MODE_DELETE, callsign(1), CALL_ZERO, 0, 32'd0);
        wait_drained();

        // lowest floor, zero timeout, plus a write nobody answers
        write_reg(REG_MIN_SIGNAL, 32'hFFFF_FF63);
        write_reg(REG_TIMEOUT, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_traffic(200, 32'd1000, -9'sd157);
        wait_drained();

        // highest floor, longest timeout
        write_reg(REG_MIN_SIGNAL, 32'd98);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_traffic(200, $urandom, 9'sd98);
        wait_drained();

        // table fills up and evicts, time wraps
        write_reg(REG_MIN_SIGNAL, 32'hFFFF_FF63);
        @(negedge clk);
        queue_traffic(400, 32'hFFFF_0000, -9'sd157);
        wait_drained();

        // back to the reset settings
        write_reg(REG_MIN_SIGNAL, 32'($signed(MIN_SIGNAL_RESET)));
        write_reg(REG_TIMEOUT, TIMEOUT_RESET);
        @(negedge clk);
        queue_traffic(400, $urandom, MIN_SIGNAL_RESET);
        wait_drained();

        // random settings inside the legal range
        begin
            int floor_dbm;
            floor_dbm = int'($urandom_range(255)) - 157;
            write_reg(REG_MIN_SIGNAL, 32'(floor_dbm));
            write_reg(REG_TIMEOUT, $urandom_range(200000, 20000));
            @(negedge clk);
            queue_traffic(300, $urandom, SIG_W'(floor_dbm));
        end
        wait_drained();

        repeat (4 * ENTRIES) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> aging_route_table.f
+incdir+rtl
rtl/art_pkg.sv
rtl/art_ctrl.sv
rtl/art_dp.sv
rtl/aging_route_table.sv
rtl/art_checker.sv
test/testbench.sv
